FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file gpt_checker.sv
// no dependencies; take in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/gpt_pkg.sv
// types and constants of the gesture peak trigger detector
// no dependencies; used by gpt_cell, gpt_scan, the top level and the testbench
package gpt_pkg;

  localparam int unsigned AngleW   = 8;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_RISE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_VERT_TOL  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HORIZ_TOL = 2'd2;

  // register reset values
  localparam logic [CfgW-1:0] MIN_RISE_RST  = 8'd10;
  localparam logic [CfgW-1:0] VERT_TOL_RST  = 8'd5;
  localparam logic [CfgW-1:0] HORIZ_TOL_RST = 8'd5;

  // one aim sample
  typedef struct packed {
    logic [AngleW-1:0] v;
    logic [AngleW-1:0] h;
  } sample_t;

  // scan sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL
  } state_e;

  // status handed from the scan sequencer to the top level
  typedef struct packed {
    logic busy;
    logic rotate;
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

FILE: hw/rtl/gpt_cell.sv
// one window cell: holds a sample and takes its neighbor's on enable
// depends on gpt_pkg
module gpt_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  gpt_pkg::sample_t d_i,
  output gpt_pkg::sample_t q_o
);
  import gpt_pkg::*;

  sample_t smp_q;
  sample_t smp_d;

  // take the neighbor's sample when the chain moves
  always_comb begin
    smp_d = en_i ? d_i : smp_q;
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  assign q_o = smp_q;

endmodule

FILE: hw/rtl/gpt_scan.sv
// scan sequencer: walks the rotating window, finds both flanks, checks tolerances
// depends on gpt_pkg
module gpt_scan #(
  parameter int unsigned WINDOW_LENGTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gpt_pkg::AngleW-1:0] peak_i,
  input  gpt_pkg::sample_t          head_i,
  input  logic [gpt_pkg::CfgW-1:0]  min_rise_i,
  input  logic [gpt_pkg::CfgW-1:0]  vert_tol_i,
  input  logic [gpt_pkg::CfgW-1:0]  horiz_tol_i,
  input  logic                      out_free_i,
  output gpt_pkg::scan_stat_t       stat_o
);
  import gpt_pkg::*;

  localparam int unsigned Half  = WINDOW_LENGTH / 2;
  localparam int unsigned StepW = $clog2(WINDOW_LENGTH);

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [AngleW-1:0]  peak_q, peak_d;
  logic               ok_q, ok_d;
  logic               lf_q, lf_d;
  logic               rf_q, rf_d;
  sample_t            left_q, left_d;
  sample_t            right_q, right_d;

  logic signed [AngleW+1:0] drop;
  logic                     is_flank;
  logic                     is_higher;
  logic signed [AngleW:0]   dv;
  logic signed [AngleW:0]   dh;
  logic [AngleW:0]          adv;
  logic [AngleW:0]          adh;
  logic                     pass;

  // flank tests on the sample at the head of the chain
  always_comb begin
    drop = {{2{peak_q[AngleW-1]}}, peak_q} - {{2{head_i.v[AngleW-1]}}, head_i.v};
    is_flank  = drop >= $signed({2'b00, min_rise_i});
    is_higher = $signed(head_i.v) > $signed(peak_q);
  end

  // tolerance check on the two flanks
  always_comb begin
    dv  = $signed({left_q.v[AngleW-1], left_q.v}) - $signed({right_q.v[AngleW-1], right_q.v});
    dh  = $signed({left_q.h[AngleW-1], left_q.h}) - $signed({right_q.h[AngleW-1], right_q.h});
    adv = dv[AngleW] ? (AngleW+1)'(-dv) : dv;
    adh = dh[AngleW] ? (AngleW+1)'(-dh) : dh;
    pass = ok_q && lf_q && rf_q
        && (adv <= {1'b0, vert_tol_i}) && (adh <= {1'b0, horiz_tol_i});
  end

  // sequencer next state and outputs
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    peak_d  = peak_q;
    ok_d    = ok_q;
    lf_d    = lf_q;
    rf_d    = rf_q;
    left_d  = left_q;
    right_d = right_q;
    stat_o  = '0;
    stat_o.busy = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
          step_d  = '0;
          peak_d  = peak_i;
          ok_d    = 1'b1;
          lf_d    = 1'b0;
          rf_d    = 1'b0;
        end
      end
      ST_SCAN: begin
        stat_o.rotate = 1'b1;
        if (step_q < StepW'(Half)) begin
          // left side, oldest toward the center
          if (ok_q && !lf_q) begin
            if (is_flank) begin
              lf_d   = 1'b1;
              left_d = head_i;
            end else if (is_higher) begin
              ok_d = 1'b0;
            end
          end
        end else if (step_q > StepW'(Half)) begin
          // right side, center toward the newest
          if (ok_q && !rf_q) begin
            if (is_flank) begin
              rf_d    = 1'b1;
              right_d = head_i;
            end else if (is_higher) begin
              ok_d = 1'b0;
            end
          end
        end
        if (step_q == StepW'(WINDOW_LENGTH - 1)) begin
          state_d = ST_EVAL;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_EVAL: begin
        if (out_free_i) begin
          stat_o.done = 1'b1;
          stat_o.hit  = pass;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    peak_q  <= peak_d;
    ok_q    <= ok_d;
    lf_q    <= lf_d;
    rf_q    <= rf_d;
    left_q  <= left_d;
    right_q <= right_d;
  end

endmodule

FILE: hw/rtl/gesture_peak_trigger_detector_top.sv
// top level of the gesture peak trigger detector: window chain, fill count,
// handshakes and registers; depends on gpt_pkg, gpt_cell and gpt_scan
//
// Usage:
// - input channel (in_valid_i / in_stall_o) carries one aim sample per beat:
//   object_present_i, vertical_angle_i, horizontal_angle_i
// - output channel (out_valid_o / out_stall_i) carries one beat per input
//   beat with triggered_o, in input order
// - config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 min_rise, 1 vertical_tolerance, 2 horizontal_tolerance; others ignored)
// - an absent sample or a sample that only fills the window shows its result
//   in the cycle after acceptance
// - a sample that arrives with the window full goes through these steps to its
//   result: it shifts in at acceptance, the window chain rotates once past the
//   scan sequencer, then the flanks are checked
// - one item is in work at a time; the next beat is stalled until the rotation
//   of the cell chain and the flank check of an evaluating item are done
// - reset empties the window, loads register defaults, drops out_valid_o
// - while the output is stalled the result holds and new beats are stalled
module gesture_peak_trigger_detector_top #(
  parameter int unsigned WINDOW_LENGTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        object_present_i,
  input  logic signed [7:0]           vertical_angle_i,
  input  logic signed [7:0]           horizontal_angle_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        triggered_o,
  input  logic                        cfg_we_i,
  input  logic [gpt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gpt_pkg::CfgW-1:0]    cfg_data_i
);
  import gpt_pkg::*;

  localparam int unsigned Half  = WINDOW_LENGTH / 2;
  localparam int unsigned FillW = $clog2(WINDOW_LENGTH + 1);

  logic [CfgW-1:0]  min_rise_q, vert_tol_q, horiz_tol_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic             out_valid_q, out_valid_d;
  logic             trig_q, trig_d;

  logic       in_acc;
  logic       full;
  logic       out_free;
  logic       shift_en;
  logic       start;
  sample_t    new_smp;
  sample_t    tail_d;
  sample_t    cell_q [WINDOW_LENGTH];
  scan_stat_t stat;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = stat.busy || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (fill_q == FillW'(WINDOW_LENGTH));
  assign start      = in_acc && object_present_i && full;
  assign new_smp    = '{v: vertical_angle_i, h: horizontal_angle_i};

  // chain moves on a present sample or during the scan rotation
  assign shift_en = (in_acc && object_present_i) || stat.rotate;
  assign tail_d   = stat.rotate ? cell_q[0] : new_smp;

  // window chain, index 0 holds the oldest sample
  for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
    if (k == WINDOW_LENGTH - 1) begin : g_tail
      gpt_cell u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .d_i   (tail_d),
        .q_o   (cell_q[k])
      );
    end else begin : g_body
      gpt_cell u_cell (
        .clk_i (clk_i),
        .en_i  (shift_en),
        .d_i   (cell_q[k+1]),
        .q_o   (cell_q[k])
      );
    end
  end

  // scan sequencer; the peak lands in the center once the new sample is in
  gpt_scan #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .peak_i      (cell_q[Half+1].v),
    .head_i      (cell_q[0]),
    .min_rise_i  (min_rise_q),
    .vert_tol_i  (vert_tol_q),
    .horiz_tol_i (horiz_tol_q),
    .out_free_i  (out_free),
    .stat_o      (stat)
  );

  // fill count and output register
  always_comb begin
    fill_d      = fill_q;
    out_valid_d = out_valid_q && out_stall_i;
    trig_d      = trig_q;
    if (in_acc) begin
      if (!object_present_i) begin
        fill_d      = '0;
        out_valid_d = 1'b1;
        trig_d      = 1'b0;
      end else if (!full) begin
        fill_d      = fill_q + FillW'(1);
        out_valid_d = 1'b1;
        trig_d      = 1'b0;
      end
    end
    if (stat.done) begin
      out_valid_d = 1'b1;
      trig_d      = stat.hit;
      if (stat.hit) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rise_q  <= MIN_RISE_RST;
      vert_tol_q  <= VERT_TOL_RST;
      horiz_tol_q <= HORIZ_TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_RISE:  min_rise_q  <= cfg_data_i;
        REG_VERT_TOL:  vert_tol_q  <= cfg_data_i;
        REG_HORIZ_TOL: horiz_tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign triggered_o = trig_q;

endmodule

FILE: hw/rtl/gpt_checker.sv
// port-level checker for the gesture peak trigger detector, bound to the top
// depends on assert_macros.svh and gesture_peak_trigger_detector_top
`include "assert_macros.svh"

module gpt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              object_present_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              triggered_o
);

  // an absent sample gives an untriggered beat right away
  `ASSERT_NEXT(a_absent_clear, clk_i, rst_ni,
    in_valid_i && !in_stall_o && !object_present_i, out_valid_o && !triggered_o)

  // an accepted beat is either answered next cycle or keeps the block busy
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni,
    in_valid_i && !in_stall_o, out_valid_o || in_stall_o)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i, out_valid_o && $stable(triggered_o))

  // no new beat is taken while a result waits stalled
  `ASSERT_NOW(a_no_overrun, clk_i, rst_ni,
    out_valid_o && out_stall_i, in_stall_o)

endmodule

bind gesture_peak_trigger_detector_top gpt_checker u_gpt_checker (.*);

FILE: tb/tb_gesture_peak_trigger_detector_top.sv
// self-checking testbench for gesture_peak_trigger_detector_top
// holds its own window predictor, a directed table and random gesture traffic
// depends on gpt_pkg and the top level rtl only
`timescale 1ns / 100ps

module tb_gesture_peak_trigger_detector_top;
  import gpt_pkg::*;

  localparam int WIN_LEN     = 16;
  localparam int HALF        = WIN_LEN / 2;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 292;
  localparam int LONG_HOLD   = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 21;
  localparam int EXP_DEPTH   = 64;

  // index past the register list, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;

  // one directed beat: payload plus an optional typed-in expectation
  typedef struct packed {
    logic              present;
    logic signed [7:0] v;
    logic signed [7:0] h;
    logic              fixed;
    logic              trig;
  } aim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                object_present_i;
  logic signed [7:0]   vertical_angle_i;
  logic signed [7:0]   horizontal_angle_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                triggered_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;

  // typed-in expectation travelling with the payload
  logic                row_fixed;
  logic                row_trig;

  // predictor state
  logic signed [7:0]   win_v [WIN_LEN];
  logic signed [7:0]   win_h [WIN_LEN];
  int                  win_fill;
  logic [CfgW-1:0]     rise_cfg;
  logic [CfgW-1:0]     vtol_cfg;
  logic [CfgW-1:0]     htol_cfg;

  // expected results in order, ring with write and read counts
  logic                exp_ring [EXP_DEPTH];
  int                  exp_wr;
  int                  exp_rd;
  int                  mismatches;
  int                  samples_sent;
  int                  cycles;
  bit                  quiet;
  bit                  long_hold;

  // walks the window: the gesture ends at the last two rows that fill
  // and then complete it
  aim_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 8'sh7f,  8'sh80,  1'b1, 1'b0},  // absent right after reset
    '{1'b1, 8'sh80,  8'sh7f,  1'b1, 1'b0},  // shifted out before the check
    '{1'b1, 8'sd0,   8'sd0,   1'b1, 1'b0},  // left flank
    '{1'b1, 8'sd10,  8'sh7f,  1'b1, 1'b0},
    '{1'b1, 8'sd20,  8'sh80,  1'b1, 1'b0},
    '{1'b1, 8'sd30,  8'sd3,   1'b1, 1'b0},
    '{1'b1, 8'sd40,  -8'sd3,  1'b1, 1'b0},
    '{1'b1, 8'sd45,  8'sd90,  1'b1, 1'b0},
    '{1'b1, 8'sd50,  -8'sd90, 1'b1, 1'b0},
    '{1'b1, 8'sd55,  8'sd0,   1'b1, 1'b0},
    '{1'b1, 8'sd60,  8'sd0,   1'b1, 1'b0},  // centre peak
    '{1'b1, 8'sd55,  8'sd1,   1'b1, 1'b0},
    '{1'b1, 8'sd55,  8'sd0,   1'b1, 1'b0},
    '{1'b1, 8'sd52,  8'sd0,   1'b1, 1'b0},
    '{1'b1, 8'sd51,  8'sd0,   1'b1, 1'b0},
    '{1'b1, 8'sd58,  8'sd0,   1'b1, 1'b0},
    '{1'b1, 8'sd53,  8'sd0,   1'b1, 1'b0},  // window full now
    '{1'b1, 8'sd0,   8'sd4,   1'b0, 1'b0},  // right flank, checked by predictor
    '{1'b1, 8'sh7f,  8'sh80,  1'b1, 1'b0},
    '{1'b1, 8'sh80,  8'sh7f,  1'b1, 1'b0},
    '{1'b0, 8'sh80,  8'sh80,  1'b1, 1'b0}   // absent empties the window
  };

  gesture_peak_trigger_detector_top #(
    .WINDOW_LENGTH(WIN_LEN)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .object_present_i   (object_present_i),
    .vertical_angle_i   (vertical_angle_i),
    .horizontal_angle_i (horizontal_angle_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .triggered_o        (triggered_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // window predictor: shift in one sample, return the trigger it causes
  function automatic logic advance_window(input logic present,
                                          input logic signed [7:0] v,
                                          input logic signed [7:0] h);
    int   i;
    int   pk;
    int   lv, lh, rv, rh;
    logic bad, lf, rf;
    bad = 1'b0;
    lf  = 1'b0;
    rf  = 1'b0;
    lv  = 0;
    lh  = 0;
    rv  = 0;
    rh  = 0;
    if (!present) begin
      win_fill = 0;
      return 1'b0;
    end
    if (win_fill < WIN_LEN) begin
      win_v[win_fill] = v;
      win_h[win_fill] = h;
      win_fill++;
      return 1'b0;
    end
    for (i = 0; i < WIN_LEN - 1; i++) begin
      win_v[i] = win_v[i + 1];
      win_h[i] = win_h[i + 1];
    end
    win_v[WIN_LEN - 1] = v;
    win_h[WIN_LEN - 1] = h;
    pk = int'(win_v[HALF]);
    // left scan from the oldest sample toward the peak
    for (i = 0; i < HALF && !bad && !lf; i++) begin
      if (pk - int'(win_v[i]) >= int'(rise_cfg)) begin
        lf = 1'b1;
        lv = int'(win_v[i]);
        lh = int'(win_h[i]);
      end else if (int'(win_v[i]) > pk) begin
        bad = 1'b1;
      end
    end
    // right scan from next to the peak outward
    for (i = HALF + 1; i < WIN_LEN && !bad && !rf; i++) begin
      if (pk - int'(win_v[i]) >= int'(rise_cfg)) begin
        rf = 1'b1;
        rv = int'(win_v[i]);
        rh = int'(win_h[i]);
      end else if (int'(win_v[i]) > pk) begin
        bad = 1'b1;
      end
    end
    if (bad || !lf || !rf) return 1'b0;
    if ((lv > rv ? lv - rv : rv - lv) > int'(vtol_cfg)) return 1'b0;
    if ((lh > rh ? lh - rh : rh - lh) > int'(htol_cfg)) return 1'b0;
    win_fill = 0;
    return 1'b1;
  endfunction

  function automatic logic signed [7:0] clamp_angle(input int x);
    if (x > 127) return 8'sh7f;
    if (x < -128) return 8'sh80;
    return 8'(x);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // one input beat; the caller is always at a rising edge here
  task automatic send_sample(input logic present, input logic signed [7:0] v,
                             input logic signed [7:0] h, input logic fixed,
                             input logic trig);
    int gap;
    in_valid_i         <= 1'b1;
    object_present_i   <= present;
    vertical_angle_i   <= v;
    horizontal_angle_i <= h;
    row_fixed          <= fixed;
    row_trig           <= trig;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every beat has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (WIN_LEN + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MIN_RISE:  rise_cfg = val;
      REG_VERT_TOL:  vtol_cfg = val;
      REG_HORIZ_TOL: htol_cfg = val;
      default: ;
    endcase
  endtask

  // hill with a plateau around the peak and a shelf on both sides
  task automatic send_gesture(input bit broken);
    int n, pp, w, sh, big, p, hb, d, brk, vi, hi, i;
    n   = 17 + int'($urandom_range(0, 7));
    pp  = int'($urandom_range(9, n - 8));
    w   = int'($urandom_range(1, 8));
    sh  = int'($urandom_range(0, 12));
    big = ($urandom_range(0, 4) == 0) ? 255 : int'($urandom_range(1, 60));
    p   = ($urandom_range(0, 4) == 0) ? 127 : int'($urandom_range(0, 180)) - 90;
    hb  = int'($urandom_range(0, 180)) - 90;
    brk = broken ? int'($urandom_range(0, n - 1)) : -1;
    if ($urandom_range(0, 1) == 0)
      send_sample(1'b0, 8'(p), 8'(hb), 1'b0, 1'b0);
    for (i = 0; i < n; i++) begin
      d = (i > pp) ? i - pp : pp - i;
      if (d == 0)
        vi = p;
      else if (d < w)
        vi = p - int'($urandom_range(0, sh));
      else if ($urandom_range(0, 3) == 0)
        vi = p - big + int'($urandom_range(0, 6)) - 3;
      else
        vi = p - big;
      hi = hb;
      if ($urandom_range(0, 3) == 0) hi = hb + int'($urandom_range(0, 8)) - 4;
      send_sample(i != brk, clamp_angle(vi), clamp_angle(hi), 1'b0, 1'b0);
    end
  endtask

  // accepted input beat: advance the predictor
  always @(posedge clk_i) begin : sample_accept
    logic trig;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      trig = advance_window(object_present_i, vertical_angle_i, horizontal_angle_i);
      exp_ring[exp_wr % EXP_DEPTH] = row_fixed ? row_trig : trig;
      exp_wr++;
    end
  end

  // accepted result beat: compare with the oldest expectation
  always @(posedge clk_i) begin : result_check
    logic want;
    if (out_valid_o && !out_stall_i) begin
      if (exp_wr == exp_rd) begin
        flag_mismatch("result beat with no sample waiting");
      end else begin
        want = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (triggered_o !== want)
          flag_mismatch($sformatf("triggered %b, want %b", triggered_o, want));
      end
    end
  end

  // receiver: short stall bursts, one long hold on request
  initial begin : rx_stall
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int  ph, r, k, pick, phase_start;
    bit  hold_done, pause_done;
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    object_present_i   <= 1'b0;
    vertical_angle_i   <= '0;
    horizontal_angle_i <= '0;
    row_fixed          <= 1'b0;
    row_trig           <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_MIN_RISE;
    cfg_data_i         <= '0;
    win_fill     = 0;
    rise_cfg     = MIN_RISE_RST;
    vtol_cfg     = VERT_TOL_RST;
    htol_cfg     = HORIZ_TOL_RST;
    exp_wr       = 0;
    exp_rd       = 0;
    mismatches   = 0;
    samples_sent = 0;
    cycles       = 0;
    quiet        = 1'b0;
    long_hold    = 1'b0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table with reset register values
    for (r = 0; r < DIR_ROWS; r++)
      send_sample(dir_rows[r].present, dir_rows[r].v, dir_rows[r].h,
                  dir_rows[r].fixed, dir_rows[r].trig);

    // random phases, one register setting each
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(REG_MIN_RISE, MIN_RISE_RST);
          write_reg(REG_VERT_TOL, VERT_TOL_RST);
          write_reg(REG_HORIZ_TOL, HORIZ_TOL_RST);
        end
        1: begin
          write_reg(REG_MIN_RISE, 8'd0);
          write_reg(REG_VERT_TOL, 8'd0);
          write_reg(REG_HORIZ_TOL, 8'd0);
          write_reg(REG_SPARE, 8'hff);
        end
        2: begin
          write_reg(REG_MIN_RISE, 8'hff);
          write_reg(REG_VERT_TOL, 8'hff);
          write_reg(REG_HORIZ_TOL, 8'hff);
        end
        3: begin
          write_reg(REG_MIN_RISE, 8'd180);
          write_reg(REG_VERT_TOL, 8'd180);
          write_reg(REG_HORIZ_TOL, 8'd180);
        end
        4: begin
          write_reg(REG_MIN_RISE, 8'($urandom_range(0, 255)));
          write_reg(REG_VERT_TOL, 8'($urandom_range(0, 255)));
          write_reg(REG_HORIZ_TOL, 8'($urandom_range(0, 255)));
          write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(REG_MIN_RISE, 8'd12);
          write_reg(REG_VERT_TOL, 8'd3);
          write_reg(REG_HORIZ_TOL, 8'd8);
        end
      endcase
      cfg_we_i <= 1'b0;
      quiet = (ph == PHASES - 1);
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) begin
        // receiver holds off while samples keep coming
        if (ph == 1 && !hold_done && samples_sent - phase_start > PHASE_ITEMS / 2) begin
          long_hold = 1'b1;
          hold_done = 1'b1;
        end
        // sender waits for every result before going on
        if (ph == 2 && !pause_done && samples_sent - phase_start > PHASE_ITEMS / 2) begin
          drain_results();
          pause_done = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_gesture(1'b0);
        end else if (pick < 9) begin
          k = $urandom_range(1, 6);
          repeat (k)
            send_sample($urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end else begin
          send_gesture(1'b1);
        end
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gpt_pkg.sv
hw/rtl/gpt_cell.sv
hw/rtl/gpt_scan.sv
hw/rtl/gesture_peak_trigger_detector_top.sv
hw/rtl/gpt_checker.sv
tb/tb_gesture_peak_trigger_detector_top.sv
